[design/fiuc_pkg.sv]
`default_nettype none

package fiuc_pkg;

	// Field widths of the byte and result beats.
	localparam int BYTE_W = 8;
	localparam int ID_W   = 24;
	localparam int LEN_W  = 8;
	localparam int UC_W   = 7;
	localparam int POS_W  = 10;

	// ID table size and the width of the fill count that indexes it.
	localparam int ID_TABLE_DEPTH = 64;
	localparam int CNT_W          = $clog2(ID_TABLE_DEPTH + 1);

	// Frame layout, counted from the end of the record header.
	localparam int LEN_OFFSET     = 1;
	localparam int ID_OFFSET      = 7;
	localparam int ID_BYTES       = 3;
	localparam int FRAME_OVERHEAD = 12;

	// Configuration port.
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 8;

	localparam logic [CFG_W-1:0] FILE_HDR_RESET = 8'd24;
	localparam logic [CFG_W-1:0] REC_HDR_RESET  = 8'd48;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FILE_HDR = 1'b0,
		REG_REC_HDR  = 1'b1
	} cfg_reg_t;

	// Frame end event from the parser to the ID table.
	typedef struct packed {
		logic             valid;
		logic [ID_W-1:0]  id;
		logic [LEN_W-1:0] len;
	} frame_evt_t;

endpackage

`default_nettype wire

[design/fiuc_if.sv]
`default_nettype none

// Byte stream channel.
interface fiuc_byte_if;
	import fiuc_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

// Per-frame result channel.
interface fiuc_result_if;
	import fiuc_pkg::*;

	logic             valid;
	logic             ready;
	logic [ID_W-1:0]  message_id;
	logic             is_new;
	logic [UC_W-1:0]  unique_count;
	logic             table_full;
	logic [LEN_W-1:0] payload_length;

	modport source (output valid, output message_id, output is_new, output unique_count,
		output table_full, output payload_length, input ready);
	modport sink   (input valid, input message_id, input is_new, input unique_count,
		input table_full, input payload_length, output ready);
endinterface

`default_nettype wire

[design/frame_id_unique_counter.sv]
`default_nettype none

// Message ID uniqueness counter for a capture byte stream.
// byte_in carries one stream byte per beat. After reset the first 24 bytes
// (register 0) are skipped, then each record is a 48-byte record header
// (register 1) followed by a v2 frame whose 3-byte ID is assembled.
// Writing register 0 also restarts the skip with the new count.
// result_out carries one beat per completed frame: the ID, whether it is
// new, the distinct-ID count, a table-full flag and the payload length.
// Bytes are taken one per cycle. The beat that ends a frame is taken only
// when the ID table is idle and the result register is empty; its result
// is registered in turn in the key register, the cell compare register and,
// after hit reduction, the result register.
// The lookup is a row of 64 cells that compare in parallel; new IDs shift in
// at the head of the row. A frame is at least 12 bytes long, so bytes keep
// flowing one per cycle unless the receiver holds a result past the next
// frame end, in which case byte_in.ready drops on that frame-ending beat.
// Reset empties the table at once (fill count zero) and restores registers.
module frame_id_unique_counter (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	fiuc_byte_if.sink                           byte_in,
	fiuc_result_if.source                       result_out,
	input  wire logic                           cfg_we,
	input  wire logic [fiuc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [fiuc_pkg::CFG_W-1:0]     cfg_data
);
	import fiuc_pkg::*;

	frame_evt_t evt;
	logic       slot_free;

	// Framing of the byte stream.
	fiuc_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_in   (byte_in),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.slot_free (slot_free),
		.evt       (evt)
	);

	// ID table lookup and result register.
	fiuc_table u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.evt        (evt),
		.slot_free  (slot_free),
		.result_out (result_out)
	);

endmodule

`default_nettype wire

[design/fiuc_parser.sv]
`default_nettype none

module fiuc_parser (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	fiuc_byte_if.sink                           byte_in,
	input  wire logic                           cfg_we,
	input  wire logic [fiuc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [fiuc_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                           slot_free,
	output fiuc_pkg::frame_evt_t                evt
);
	import fiuc_pkg::*;

	logic [CFG_W-1:0] skip_q;
	logic [CFG_W-1:0] rh_q;
	logic [POS_W-1:0] pos_q;
	logic [LEN_W-1:0] len_q;
	logic [ID_W-1:0]  id_q;

	logic [POS_W:0]   pos_next;
	logic [POS_W:0]   end_thr;
	logic             end_now;
	logic             accept;
	logic             is_len_byte;
	logic [POS_W-1:0] id_base;
	logic [POS_W-1:0] id_rel;
	logic             is_id_byte;

	// Frame end depends only on the held state, never on the byte itself.
	always_comb begin
		pos_next    = {1'b0, pos_q} + (POS_W+1)'(1);
		end_thr     = (POS_W+1)'(rh_q) + (POS_W+1)'(len_q) + (POS_W+1)'(FRAME_OVERHEAD);
		end_now     = (skip_q == '0) && (pos_next >= end_thr);
		is_len_byte = pos_q == (POS_W'(rh_q) + POS_W'(LEN_OFFSET));
		id_base     = POS_W'(rh_q) + POS_W'(ID_OFFSET);
		id_rel      = pos_q - id_base;
		is_id_byte  = (pos_q >= id_base) && (id_rel < POS_W'(ID_BYTES));
	end

	// A frame-ending beat waits until the table can take its lookup.
	assign byte_in.ready = !end_now || slot_free;
	assign accept        = byte_in.valid && byte_in.ready;

	assign evt.valid = accept && end_now;
	assign evt.id    = id_q;
	assign evt.len   = len_q;

	// Framing state and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= FILE_HDR_RESET;
			rh_q   <= REC_HDR_RESET;
			pos_q  <= '0;
			len_q  <= '0;
			id_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FILE_HDR: skip_q <= cfg_data;
				REG_REC_HDR:  rh_q   <= cfg_data;
			endcase
		end else if (accept) begin
			if (skip_q != '0) begin
				skip_q <= skip_q - CFG_W'(1);
			end else if (end_now) begin
				pos_q <= '0;
				len_q <= '0;
				id_q  <= '0;
			end else begin
				pos_q <= pos_next[POS_W-1:0];
				if (is_len_byte) begin
					len_q <= byte_in.data_byte;
				end else if (is_id_byte) begin
					unique case (id_rel[1:0])
						2'd0:    id_q[7:0]   <= byte_in.data_byte;
						2'd1:    id_q[15:8]  <= byte_in.data_byte;
						2'd2:    id_q[23:16] <= byte_in.data_byte;
						default: id_q        <= id_q;
					endcase
				end
			end
		end
	end

endmodule

`default_nettype wire

[design/fiuc_cell.sv]
`default_nettype none

module fiuc_cell (
	input  wire logic                      clk,
	input  wire logic                      shift_en,
	input  wire logic [fiuc_pkg::ID_W-1:0] shift_in,
	input  wire logic [fiuc_pkg::ID_W-1:0] key,
	input  wire logic                      en,
	output logic      [fiuc_pkg::ID_W-1:0] entry,
	output logic                           hit
);
	import fiuc_pkg::*;

	logic [ID_W-1:0] entry_q;
	logic            hit_s2;

	// The entry moves one cell down the row on every insertion.
	always_ff @(posedge clk) begin
		if (shift_en) begin
			entry_q <= shift_in;
		end
		hit_s2 <= en && (entry_q == key);
	end

	assign entry = entry_q;
	assign hit   = hit_s2;

endmodule

`default_nettype wire

[design/fiuc_table.sv]
`default_nettype none

module fiuc_table (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  fiuc_pkg::frame_evt_t evt,
	output logic                slot_free,
	fiuc_result_if.source       result_out
);
	import fiuc_pkg::*;

	logic             v_s1;
	logic             v_s2;
	logic [ID_W-1:0]  key_q;
	logic [LEN_W-1:0] len_q;
	logic [CNT_W-1:0] count_q;

	logic             out_valid_q;
	logic [ID_W-1:0]  out_id_q;
	logic             out_new_q;
	logic [UC_W-1:0]  out_count_q;
	logic             out_full_q;
	logic [LEN_W-1:0] out_len_q;

	logic [ID_TABLE_DEPTH-1:0] hit;
	logic [ID_W-1:0]           entry [ID_TABLE_DEPTH];
	logic                      found;
	logic                      is_new;
	logic                      full;
	logic                      insert;
	logic [CNT_W-1:0]          count_next;

	// Row of cells; cell zero takes the newest ID.
	for (genvar i = 0; i < ID_TABLE_DEPTH; i++) begin : g_cell
		logic [ID_W-1:0] shift_in;
		if (i == 0) begin : g_head
			assign shift_in = key_q;
		end else begin : g_body
			assign shift_in = entry[i-1];
		end
		fiuc_cell u_cell (
			.clk      (clk),
			.shift_en (insert),
			.shift_in (shift_in),
			.key      (key_q),
			.en       (CNT_W'(i) < count_q),
			.entry    (entry[i]),
			.hit      (hit[i])
		);
	end

	// Second stage: reduce the registered cell hits and decide insertion.
	always_comb begin
		found      = |hit;
		is_new     = !found;
		full       = is_new && (count_q == CNT_W'(ID_TABLE_DEPTH));
		insert     = v_s2 && is_new && !full;
		count_next = insert ? count_q + CNT_W'(1) : count_q;
	end

	// Only one lookup is in flight, and only into an empty output register.
	assign slot_free = !v_s1 && !v_s2 && !out_valid_q;

	// Lookup control and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1    <= evt.valid;
			v_s2    <= v_s1;
			count_q <= count_next;
			if (v_s2) begin
				out_valid_q <= 1'b1;
			end else if (result_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Lookup key and result payload.
	always_ff @(posedge clk) begin
		if (evt.valid) begin
			key_q <= evt.id;
			len_q <= evt.len;
		end
		if (v_s2) begin
			out_id_q    <= key_q;
			out_new_q   <= is_new;
			out_count_q <= UC_W'(count_next);
			out_full_q  <= full;
			out_len_q   <= len_q;
		end
	end

	assign result_out.valid          = out_valid_q;
	assign result_out.message_id     = out_id_q;
	assign result_out.is_new         = out_new_q;
	assign result_out.unique_count   = out_count_q;
	assign result_out.table_full     = out_full_q;
	assign result_out.payload_length = out_len_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ID_TABLE_DEPTH))
		else $error("ID table fill count beyond depth");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({v_s1, v_s2, out_valid_q}))
		else $error("more than one lookup in flight");

	a_evt_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		evt.valid |-> slot_free)
		else $error("frame end while table busy");

	a_insert_counts: assert property (@(posedge clk) disable iff (!arst_n)
		insert |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insertion did not advance the fill count");
`endif

endmodule

`default_nettype wire
